@@ src/ieu_pkg.sv @@
`timescale 1ns / 1ps
// ieu_pkg: shared types, opcodes, decode table and decode function for the
// integer execute unit. No dependencies.
package ieu_pkg;

    localparam int XLEN   = 32;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd1;
    localparam logic [STAT_W-1:0] ST_BREAK   = 3'd2;
    localparam logic [STAT_W-1:0] ST_SYSCALL = 3'd3;
    localparam logic [STAT_W-1:0] ST_HANDED  = 3'd4;

    typedef enum logic [5:0] {
        OP_ILL, OP_HAND, OP_NOP, OP_ADD, OP_SUB, OP_SLT, OP_SLTU, OP_NOR, OP_AND,
        OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA, OP_MUL, OP_MULH, OP_MULHU, OP_DIV,
        OP_MOD, OP_DIVU, OP_MODU, OP_BRK, OP_SYS, OP_SLLI, OP_SRLI, OP_SRAI,
        OP_SLTI, OP_SLTUI, OP_ADDI, OP_ANDI, OP_ORI, OP_XORI, OP_LU12I,
        OP_PCADDU12I, OP_JIRL, OP_B, OP_BL, OP_BEQ, OP_BNE, OP_BLT, OP_BGE,
        OP_BLTU, OP_BGEU
    } t_op;

    typedef enum logic [1:0] {
        MSEL_NONE, MSEL_LO, MSEL_HI
    } t_msel;

    typedef struct packed {
        logic [31:0] match;
        logic [31:0] mask;
        t_op         op;
    } t_dec;

    // payload that rides alongside the divider
    typedef struct packed {
        logic              wen;
        logic [IDX_W-1:0]  widx;
        logic [XLEN-1:0]   val;
        logic [XLEN-1:0]   npc;
        logic [STAT_W-1:0] status;
        logic              is_div;
        logic              want_rem;
        logic              neg_q;
        logic              neg_r;
        logic              zero_div;
        logic [XLEN-1:0]   dividend;
    } t_side;

    localparam int DEC_N = 65;

    localparam t_dec DEC_TABLE [DEC_N] = '{
        '{32'h00006000, 32'hfffffc1f, OP_HAND}, '{32'h00006000, 32'hffffffe0, OP_HAND},
        '{32'h00006400, 32'hffffffe0, OP_HAND},
        '{32'h00100000, 32'hffff8000, OP_ADD},  '{32'h00110000, 32'hffff8000, OP_SUB},
        '{32'h00120000, 32'hffff8000, OP_SLT},  '{32'h00128000, 32'hffff8000, OP_SLTU},
        '{32'h00140000, 32'hffff8000, OP_NOR},  '{32'h00148000, 32'hffff8000, OP_AND},
        '{32'h00150000, 32'hffff8000, OP_OR},   '{32'h00158000, 32'hffff8000, OP_XOR},
        '{32'h00170000, 32'hffff8000, OP_SLL},  '{32'h00178000, 32'hffff8000, OP_SRL},
        '{32'h00180000, 32'hffff8000, OP_SRA},  '{32'h001c0000, 32'hffff8000, OP_MUL},
        '{32'h001c8000, 32'hffff8000, OP_MULH}, '{32'h001d0000, 32'hffff8000, OP_MULHU},
        '{32'h00200000, 32'hffff8000, OP_DIV},  '{32'h00208000, 32'hffff8000, OP_MOD},
        '{32'h00210000, 32'hffff8000, OP_DIVU}, '{32'h00218000, 32'hffff8000, OP_MODU},
        '{32'h002a0000, 32'hffff8000, OP_BRK},  '{32'h002b0000, 32'hffff8000, OP_SYS},
        '{32'h00408000, 32'hffff8000, OP_SLLI}, '{32'h00448000, 32'hffff8000, OP_SRLI},
        '{32'h00488000, 32'hffff8000, OP_SRAI},
        '{32'h02000000, 32'hffc00000, OP_SLTI}, '{32'h02400000, 32'hffc00000, OP_SLTUI},
        '{32'h02800000, 32'hffc00000, OP_ADDI}, '{32'h03400000, 32'hffc00000, OP_ANDI},
        '{32'h03800000, 32'hffc00000, OP_ORI},  '{32'h03c00000, 32'hffc00000, OP_XORI},
        '{32'h04000000, 32'hff000000, OP_HAND}, '{32'h06000000, 32'hffc00000, OP_HAND},
        '{32'h06482800, 32'hffffffff, OP_HAND}, '{32'h06482c00, 32'hffffffff, OP_HAND},
        '{32'h06483000, 32'hffffffff, OP_HAND}, '{32'h06483400, 32'hffffffff, OP_HAND},
        '{32'h06483800, 32'hffffffff, OP_HAND}, '{32'h06488000, 32'hffff8000, OP_HAND},
        '{32'h06498000, 32'hffff8000, OP_HAND},
        '{32'h14000000, 32'hfe000000, OP_LU12I}, '{32'h1c000000, 32'hfe000000, OP_PCADDU12I},
        '{32'h20000000, 32'hff000000, OP_HAND}, '{32'h21000000, 32'hff000000, OP_HAND},
        '{32'h28000000, 32'hffc00000, OP_HAND}, '{32'h28400000, 32'hffc00000, OP_HAND},
        '{32'h28800000, 32'hffc00000, OP_HAND}, '{32'h29000000, 32'hffc00000, OP_HAND},
        '{32'h29400000, 32'hffc00000, OP_HAND}, '{32'h29800000, 32'hffc00000, OP_HAND},
        '{32'h2a000000, 32'hffc00000, OP_HAND}, '{32'h2a400000, 32'hffc00000, OP_HAND},
        '{32'h2ac00000, 32'hffc00000, OP_NOP},  '{32'h38720000, 32'hffff8000, OP_NOP},
        '{32'h38728000, 32'hffff8000, OP_NOP},
        '{32'h4c000000, 32'hfc000000, OP_JIRL}, '{32'h50000000, 32'hfc000000, OP_B},
        '{32'h54000000, 32'hfc000000, OP_BL},   '{32'h58000000, 32'hfc000000, OP_BEQ},
        '{32'h5c000000, 32'hfc000000, OP_BNE},  '{32'h60000000, 32'hfc000000, OP_BLT},
        '{32'h64000000, 32'hfc000000, OP_BGE},  '{32'h68000000, 32'hfc000000, OP_BLTU},
        '{32'h6c000000, 32'hfc000000, OP_BGEU}
    };

    // first matching entry wins: scan from the back so earlier entries override
    function automatic t_op decode(input logic [31:0] inst);
        t_op op;
        op = OP_ILL;
        for (int i = DEC_N - 1; i >= 0; i--) begin
            if (((inst ^ DEC_TABLE[i].match) & DEC_TABLE[i].mask) == 32'h0) begin
                op = DEC_TABLE[i].op;
            end
        end
        return op;
    endfunction

endpackage

@@ src/integer_execute_unit.sv @@
`timescale 1ns / 1ps
// integer_execute_unit: top level of the integer ALU / branch execute unit.
// Depends on ieu_pkg and ieu_div_pipe.
//
// Usage:
//  - Slave channel s_axis_*: one transaction carries an instruction word, its pc
//    and the rj, rk and rd register values. Master channel m_axis_*: one
//    transaction per instruction with write-back enable, index, value, next pc
//    and status (ok, illegal, break, syscall, handed on).
//  - Every instruction takes the same path, so results leave in issue order.
//    From acceptance to m_axis_tvalid there are 36 register stages,
//    the first loaded at the accepting edge: input register, decode register,
//    execute register (ALU, branch, 32x32 multiply), 32 divider stages (one
//    quotient bit per stage), output register.
//  - One transaction per cycle unless stalled; the divider is fully pipelined.
//  - Reset (i_rst_n low, synchronous) clears all valid bits; data registers
//    are not reset.
//  - When the receiver holds m_axis_tready low with a result pending, the whole
//    pipeline freezes and s_axis_tready drops in the same cycle; nothing is lost
//    or repeated. Bubbles in the pipe do not fill while frozen.
module integer_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] inst, [63:32] pc, [95:64] rj_value, [127:96] rk_value,
    // [159:128] rd_value
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] write_enable, [5:1] write_index, [37:6] write_value,
    // [69:38] next_pc, [72:70] status, [79:73] zero
    output logic [79:0]  m_axis_tdata
);
    import ieu_pkg::*;

    localparam int SIDE_W = $bits(t_side);

    logic w_en;

    // stage 0: input register
    logic            r0_vld;
    logic [XLEN-1:0] r0_inst, r0_pc, r0_rj, r0_rk, r0_rd;

    // stage 1: decoded
    logic            r1_vld;
    t_op             r1_op;
    logic [XLEN-1:0] r1_inst, r1_pc, r1_rj, r1_rk, r1_rd;

    // stage 2: executed
    logic                r2_vld;
    t_side               r2_side;
    t_msel               r2_msel;
    logic [2*XLEN-1:0]   r2_prod;
    logic [XLEN-1:0]     r2_da, r2_db;

    // output register
    logic        r_out_vld;
    logic [79:0] r_out_data;

    // whole pipe moves together unless a result is stuck at the output
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
        end else if (w_en) begin
            r0_vld    <= s_axis_tvalid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_inst <= s_axis_tdata[31:0];
            r0_pc   <= s_axis_tdata[63:32];
            r0_rj   <= s_axis_tdata[95:64];
            r0_rk   <= s_axis_tdata[127:96];
            r0_rd   <= s_axis_tdata[159:128];
            r1_op   <= decode(r0_inst);
            r1_inst <= r0_inst;
            r1_pc   <= r0_pc;
            r1_rj   <= r0_rj;
            r1_rk   <= r0_rk;
            r1_rd   <= r0_rd;
        end
    end

    // ---------------- execute ----------------
    logic [XLEN-1:0] w_si12, w_ui12, w_off16, w_off26, w_up20, w_pc4, w_br_tgt;
    logic [4:0]      w_sh5, w_rsh;
    logic            w_lt_s, w_lt_u;
    logic            w_msigned_j, w_msigned_k;
    logic signed [XLEN:0]     w_ma, w_mb;
    logic signed [2*XLEN+1:0] w_prod;
    logic            w_sdiv, w_na, w_nb;
    t_side           n_side;
    t_msel           n_msel;

    assign w_si12   = {{20{r1_inst[21]}}, r1_inst[21:10]};
    assign w_ui12   = {20'b0, r1_inst[21:10]};
    assign w_sh5    = r1_inst[14:10];
    assign w_rsh    = r1_rk[4:0];
    assign w_off16  = {{14{r1_inst[25]}}, r1_inst[25:10], 2'b00};
    assign w_off26  = {{4{r1_inst[9]}}, r1_inst[9:0], r1_inst[25:10], 2'b00};
    assign w_up20   = {r1_inst[24:5], 12'b0};
    assign w_pc4    = r1_pc + 32'd4;
    assign w_br_tgt = r1_pc + w_off16;
    assign w_lt_s   = $signed(r1_rj) < $signed(r1_rd);
    assign w_lt_u   = r1_rj < r1_rd;

    // 33x33 signed product covers both signed and unsigned high halves
    assign w_msigned_j = (r1_op == OP_MULH) && r1_rj[XLEN-1];
    assign w_msigned_k = (r1_op == OP_MULH) && r1_rk[XLEN-1];
    assign w_ma   = $signed({w_msigned_j, r1_rj});
    assign w_mb   = $signed({w_msigned_k, r1_rk});
    assign w_prod = w_ma * w_mb;

    assign w_sdiv = (r1_op == OP_DIV) || (r1_op == OP_MOD);
    assign w_na   = w_sdiv && r1_rj[XLEN-1];
    assign w_nb   = w_sdiv && r1_rk[XLEN-1];

    always_comb begin
        n_side          = '0;
        n_side.widx     = r1_inst[4:0];
        n_side.npc      = w_pc4;
        n_side.status   = ST_OK;
        n_side.neg_q    = w_na ^ w_nb;
        n_side.neg_r    = w_na;
        n_side.zero_div = (r1_rk == '0);
        n_side.dividend = r1_rj;
        n_msel          = MSEL_NONE;
        case (r1_op)
            OP_HAND:  n_side.status = ST_HANDED;
            OP_NOP:   ;
            OP_ADD:   begin n_side.wen = 1'b1; n_side.val = r1_rj + r1_rk; end
            OP_SUB:   begin n_side.wen = 1'b1; n_side.val = r1_rj - r1_rk; end
            OP_SLT:   begin
                n_side.wen = 1'b1;
                n_side.val = {31'b0, $signed(r1_rj) < $signed(r1_rk)};
            end
            OP_SLTU:  begin n_side.wen = 1'b1; n_side.val = {31'b0, r1_rj < r1_rk}; end
            OP_NOR:   begin n_side.wen = 1'b1; n_side.val = ~(r1_rj | r1_rk); end
            OP_AND:   begin n_side.wen = 1'b1; n_side.val = r1_rj & r1_rk; end
            OP_OR:    begin n_side.wen = 1'b1; n_side.val = r1_rj | r1_rk; end
            OP_XOR:   begin n_side.wen = 1'b1; n_side.val = r1_rj ^ r1_rk; end
            OP_SLL:   begin n_side.wen = 1'b1; n_side.val = r1_rj << w_rsh; end
            OP_SRL:   begin n_side.wen = 1'b1; n_side.val = r1_rj >> w_rsh; end
            OP_SRA:   begin n_side.wen = 1'b1; n_side.val = $signed(r1_rj) >>> w_rsh; end
            OP_MUL:   begin n_side.wen = 1'b1; n_msel = MSEL_LO; end
            OP_MULH, OP_MULHU: begin n_side.wen = 1'b1; n_msel = MSEL_HI; end
            OP_DIV:   begin n_side.wen = 1'b1; n_side.is_div = 1'b1; end
            OP_MOD:   begin
                n_side.wen = 1'b1; n_side.is_div = 1'b1; n_side.want_rem = 1'b1;
            end
            OP_DIVU:  begin n_side.wen = 1'b1; n_side.is_div = 1'b1; end
            OP_MODU:  begin
                n_side.wen = 1'b1; n_side.is_div = 1'b1; n_side.want_rem = 1'b1;
            end
            OP_BRK:   n_side.status = ST_BREAK;
            OP_SYS:   n_side.status = ST_SYSCALL;
            OP_SLLI:  begin n_side.wen = 1'b1; n_side.val = r1_rj << w_sh5; end
            OP_SRLI:  begin n_side.wen = 1'b1; n_side.val = r1_rj >> w_sh5; end
            OP_SRAI:  begin n_side.wen = 1'b1; n_side.val = $signed(r1_rj) >>> w_sh5; end
            OP_SLTI:  begin
                n_side.wen = 1'b1;
                n_side.val = {31'b0, $signed(r1_rj) < $signed(w_si12)};
            end
            OP_SLTUI: begin n_side.wen = 1'b1; n_side.val = {31'b0, r1_rj < w_si12}; end
            OP_ADDI:  begin n_side.wen = 1'b1; n_side.val = r1_rj + w_si12; end
            OP_ANDI:  begin n_side.wen = 1'b1; n_side.val = r1_rj & w_ui12; end
            OP_ORI:   begin n_side.wen = 1'b1; n_side.val = r1_rj | w_ui12; end
            OP_XORI:  begin n_side.wen = 1'b1; n_side.val = r1_rj ^ w_ui12; end
            OP_LU12I: begin n_side.wen = 1'b1; n_side.val = w_up20; end
            OP_PCADDU12I: begin n_side.wen = 1'b1; n_side.val = r1_pc + w_up20; end
            OP_JIRL:  begin
                n_side.wen = 1'b1; n_side.val = w_pc4; n_side.npc = r1_rj + w_off16;
            end
            OP_B:     n_side.npc = r1_pc + w_off26;
            OP_BL:    begin
                n_side.wen = 1'b1; n_side.widx = 5'd1; n_side.val = w_pc4;
                n_side.npc = r1_pc + w_off26;
            end
            OP_BEQ:   if (r1_rj == r1_rd) n_side.npc = w_br_tgt;
            OP_BNE:   if (r1_rj != r1_rd) n_side.npc = w_br_tgt;
            OP_BLT:   if (w_lt_s)  n_side.npc = w_br_tgt;
            OP_BGE:   if (!w_lt_s) n_side.npc = w_br_tgt;
            OP_BLTU:  if (w_lt_u)  n_side.npc = w_br_tgt;
            OP_BGEU:  if (!w_lt_u) n_side.npc = w_br_tgt;
            default:  n_side.status = ST_ILLEGAL;
        endcase
        // register zero is never written; a dropped write reads back as zeros
        if (!n_side.wen || (n_side.widx == '0)) begin
            n_side.wen      = 1'b0;
            n_side.widx     = '0;
            n_side.val      = '0;
            n_side.is_div   = 1'b0;
            n_msel          = MSEL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side <= n_side;
            r2_msel <= n_msel;
            r2_prod <= w_prod[2*XLEN-1:0];
            r2_da   <= w_na ? (32'd0 - r1_rj) : r1_rj;
            r2_db   <= w_nb ? (32'd0 - r1_rk) : r1_rk;
        end
    end

    // multiply result folded in ahead of the divider
    t_side w_div_side;

    always_comb begin
        w_div_side = r2_side;
        case (r2_msel)
            MSEL_LO:   w_div_side.val = r2_prod[XLEN-1:0];
            MSEL_HI:   w_div_side.val = r2_prod[2*XLEN-1:XLEN];
            default:   ;
        endcase
    end

    logic              w_dv_vld;
    logic [XLEN-1:0]   w_quot, w_rem;
    logic [SIDE_W-1:0] w_dv_side_bits;
    t_side             w_fin;

    ieu_div_pipe #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r2_vld),
        .i_dividend (r2_da),
        .i_divisor  (r2_db),
        .i_side     (w_div_side),
        .o_valid    (w_dv_vld),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_side     (w_dv_side_bits)
    );

    // sign fix-up and the zero-divisor rule
    always_comb begin
        w_fin = t_side'(w_dv_side_bits);
        if (w_fin.is_div) begin
            if (w_fin.zero_div) begin
                w_fin.val = w_fin.want_rem ? w_fin.dividend : '1;
            end else if (w_fin.want_rem) begin
                w_fin.val = w_fin.neg_r ? (32'd0 - w_rem) : w_rem;
            end else begin
                w_fin.val = w_fin.neg_q ? (32'd0 - w_quot) : w_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {7'b0, w_fin.status, w_fin.npc, w_fin.val, w_fin.widx, w_fin.wen};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ src/ieu_div_pipe.sv @@
`timescale 1ns / 1ps
// ieu_div_pipe: fully pipelined restoring divider, one quotient bit per stage,
// with a sideband payload. Depends on ieu_pkg.
module ieu_div_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [ieu_pkg::XLEN-1:0] i_dividend,
    input  logic [ieu_pkg::XLEN-1:0] i_divisor,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [ieu_pkg::XLEN-1:0] o_quot,
    output logic [ieu_pkg::XLEN-1:0] o_rem,
    output logic [SIDE_W-1:0]       o_side
);
    import ieu_pkg::*;

    localparam int STEPS = XLEN;

    logic              r_vld  [STEPS];
    logic [XLEN-1:0]   r_rem  [STEPS];
    logic [XLEN-1:0]   r_quo  [STEPS];
    logic [XLEN-1:0]   r_dsr  [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              w_vld;
        logic [XLEN-1:0]   w_rem, w_quo, w_dsr;
        logic [SIDE_W-1:0] w_side;
        logic [XLEN:0]     w_trial, w_diff;
        logic              w_ge;
        logic [XLEN-1:0]   n_rem, n_quo;

        if (k == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = '0;
            assign w_quo  = i_dividend;
            assign w_dsr  = i_divisor;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_dsr  = r_dsr[k-1];
            assign w_side = r_side[k-1];
        end

        // partial remainder stays below the divisor, so the difference fits
        assign w_trial = {w_rem, w_quo[XLEN-1]};
        assign w_diff  = w_trial - {1'b0, w_dsr};
        assign w_ge    = (w_trial >= {1'b0, w_dsr});
        assign n_rem   = w_ge ? w_diff[XLEN-1:0] : w_trial[XLEN-1:0];
        assign n_quo   = {w_quo[XLEN-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_dsr[k]  <= w_dsr;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_quot  = r_quo[STEPS-1];
    assign o_rem   = r_rem[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ src/ieu_checker.sv @@
`timescale 1ns / 1ps
// ieu_checker: port-level assertions for integer_execute_unit, with the bind
// that attaches it. Depends on integer_execute_unit ports only.
module ieu_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_no_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[5:1] != 5'd0)
        else $error("write to register zero");

    a_fault_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[72:70] != 3'd0) |->
            !m_axis_tdata[0] && (m_axis_tdata[37:6] == 32'd0))
        else $error("write with non-ok status");

endmodule

bind integer_execute_unit ieu_checker u_ieu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
